/* rtl/core/tccw_pkg.sv */
`default_nettype none

package tccw_pkg;

    // Screen geometry
    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int COL_W       = $clog2(SCREEN_COLS + 4);
    localparam int ROW_W       = $clog2(SCREEN_ROWS);

    // Digit scratch
    localparam int DIGIT_DEPTH = 10;
    localparam int DIG_AW      = $clog2(DIGIT_DEPTH);
    localparam int CNT_W       = $clog2(DIGIT_DEPTH + 1);

    // Reciprocal of ten: (v * RECIP10) >> 35 == v / 10 for any 32-bit v
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    // Request codes
    localparam logic [2:0] REQ_CHAR   = 3'd0;
    localparam logic [2:0] REQ_DEC    = 3'd1;
    localparam logic [2:0] REQ_HEX    = 3'd2;
    localparam logic [2:0] REQ_HEX0X  = 3'd3;
    localparam logic [2:0] REQ_SETCUR = 3'd4;

    // Character codes
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_X = 8'h78;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  char_code;
        logic [31:0] number_value;
        logic [7:0]  text_color;
        logic [7:0]  new_col;
        logic [7:0]  new_row;
    } t_req;

    typedef struct packed {
        logic [10:0] cell_index;
        logic [7:0]  cell_char;
        logic [7:0]  cell_attr;
        logic        last_write;
    } t_cell;

    // Microcode
    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_WAIT   = 3'd0;
    localparam t_upc U_CHAR   = 3'd1;
    localparam t_upc U_SETCUR = 3'd2;
    localparam t_upc U_PFX0   = 3'd3;
    localparam t_upc U_PFXX   = 3'd4;
    localparam t_upc U_MUL    = 3'd5;
    localparam t_upc U_DIGIT  = 3'd6;
    localparam t_upc U_EMITD  = 3'd7;

    typedef enum logic [2:0] {
        ACT_WAIT,
        ACT_CHAR,
        ACT_SETCUR,
        ACT_PFX0,
        ACT_PFXX,
        ACT_MUL,
        ACT_DIGIT,
        ACT_EMITD
    } t_act;

    typedef enum logic [2:0] {
        CND_NEXT,      // go to step + 1
        CND_JUMP,      // go to target
        CND_DISPATCH,  // hold until an input beat, then jump by request type
        CND_MORE_DIG,  // more digits to convert: target, else step + 1
        CND_HOLD_LAST  // repeat until the last digit, then target
    } t_cond;

    typedef struct packed {
        t_act  act;
        t_cond cond;
        t_upc  target;
    } t_uword;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        case (upc)
            U_WAIT:   w = '{act: ACT_WAIT,   cond: CND_DISPATCH,  target: U_WAIT};
            U_CHAR:   w = '{act: ACT_CHAR,   cond: CND_JUMP,      target: U_WAIT};
            U_SETCUR: w = '{act: ACT_SETCUR, cond: CND_JUMP,      target: U_WAIT};
            U_PFX0:   w = '{act: ACT_PFX0,   cond: CND_NEXT,      target: U_WAIT};
            U_PFXX:   w = '{act: ACT_PFXX,   cond: CND_NEXT,      target: U_WAIT};
            U_MUL:    w = '{act: ACT_MUL,    cond: CND_NEXT,      target: U_WAIT};
            U_DIGIT:  w = '{act: ACT_DIGIT,  cond: CND_MORE_DIG,  target: U_MUL};
            U_EMITD:  w = '{act: ACT_EMITD,  cond: CND_HOLD_LAST, target: U_WAIT};
            default:  w = '{act: ACT_WAIT,   cond: CND_JUMP,      target: U_WAIT};
        endcase
        return w;
    endfunction

    // Entry step for each request type; unused types are dropped
    function automatic t_upc dispatch(input logic [2:0] req_type);
        t_upc u;
        case (req_type)
            REQ_CHAR:   u = U_CHAR;
            REQ_DEC:    u = U_MUL;
            REQ_HEX:    u = U_MUL;
            REQ_HEX0X:  u = U_PFX0;
            REQ_SETCUR: u = U_SETCUR;
            default:    u = U_WAIT;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/text_console_cell_writer_unit.sv */
// Sequence: a request is taken in the wait step; a character or 0x prefix beat goes into the
//   output register from the step that the request dispatches to; a number first runs the
//   multiply/digit loop once per digit (D digits), then prints the stored digits one beat each.
// One request at a time: o_ready is high only in the wait step, and a held output beat stalls.
// Reset (synchronous, active low): cursor to row 0 column 0, sequencer to its wait step,
//   output register empty; the digit scratch is not cleared.
`default_nettype none

module text_console_cell_writer_unit
    import tccw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_req  i_data,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_cell      o_data
);

    // Registers
    t_upc             r_upc,   n_upc;
    t_req             r_req,   n_req;
    logic [COL_W-1:0] r_col,   n_col;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [31:0]      r_val,   n_val;
    logic [63:0]      r_prod,  n_prod;
    logic [CNT_W-1:0] r_cnt,   n_cnt;
    logic             r_out_valid, n_out_valid;
    t_cell            r_out,   n_out;
    logic [3:0]       r_dig [DIGIT_DEPTH];

    t_uword           w_uw;
    logic             w_beat;
    logic             w_out_free;
    logic             w_emit;
    logic             w_hold;
    logic [7:0]       w_emit_char;
    logic             w_emit_last;
    logic [31:0]      w_q;
    logic [31:0]      w_rem;
    logic [3:0]       w_digit;
    logic             w_more_dig;
    logic             w_dig_we;
    logic [DIG_AW-1:0] w_rd_idx;
    logic [3:0]       w_rd_dig;
    logic [COL_W-1:0] w_col_adv;
    logic [ROW_W:0]   w_row_inc;

    assign w_uw       = ucode(r_upc);
    assign o_ready    = (r_upc == U_WAIT);
    assign w_beat     = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // Digit datapath: decimal by reciprocal multiply, hex by nibble shift
    assign w_q = (r_req.req_type == REQ_DEC) ? {3'd0, r_prod[63:35]} : {4'd0, r_val[31:4]};
    assign w_rem   = r_val - ({w_q[28:0], 3'd0} + {w_q[30:0], 1'd0});
    assign w_digit = (r_req.req_type == REQ_DEC) ? w_rem[3:0] : r_val[3:0];
    assign w_more_dig = (w_q != 32'd0) && (r_cnt != CNT_W'(DIGIT_DEPTH - 1));

    assign w_rd_idx = DIG_AW'(r_cnt - CNT_W'(1));
    assign w_rd_dig = r_dig[w_rd_idx];

    // Which steps put a cell beat out, and what it carries
    always_comb begin
        w_emit      = 1'b0;
        w_emit_char = r_req.char_code;
        w_emit_last = 1'b1;
        case (w_uw.act)
            ACT_CHAR: begin
                w_emit = (r_req.char_code != CH_TAB) && (r_req.char_code != CH_NL);
            end
            ACT_PFX0: begin
                w_emit      = 1'b1;
                w_emit_char = CH_ZERO;
                w_emit_last = 1'b0;
            end
            ACT_PFXX: begin
                w_emit      = 1'b1;
                w_emit_char = CH_LOWER_X;
                w_emit_last = 1'b0;
            end
            ACT_EMITD: begin
                w_emit      = 1'b1;
                w_emit_char = (w_rd_dig <= 4'd9) ? CH_ZERO + {4'd0, w_rd_dig}
                                                 : CH_UPPER_A + {4'd0, w_rd_dig} - 8'd10;
                w_emit_last = (r_cnt == CNT_W'(1));
            end
            default: begin
                w_emit = 1'b0;
            end
        endcase
    end

    assign w_hold = w_emit && !w_out_free;

    // Cursor advance helpers
    assign w_col_adv = r_col + ((w_uw.act == ACT_CHAR && !w_emit) ? COL_W'(4) : COL_W'(1));
    assign w_row_inc = {1'b0, r_row} + (ROW_W + 1)'(1);

    // Sequencer and datapath next state
    always_comb begin
        n_upc       = r_upc;
        n_req       = r_req;
        n_col       = r_col;
        n_row       = r_row;
        n_val       = r_val;
        n_prod      = r_prod;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;
        w_dig_we    = 1'b0;

        if (!w_hold) begin
            // step sequencing
            case (w_uw.cond)
                CND_NEXT:      n_upc = r_upc + t_upc'(1);
                CND_JUMP:      n_upc = w_uw.target;
                CND_DISPATCH:  n_upc = w_beat ? dispatch(i_data.req_type) : r_upc;
                CND_MORE_DIG:  n_upc = w_more_dig ? w_uw.target : r_upc + t_upc'(1);
                CND_HOLD_LAST: n_upc = w_emit_last ? w_uw.target : r_upc;
                default:       n_upc = U_WAIT;
            endcase

            // datapath action
            case (w_uw.act)
                ACT_WAIT: begin
                    if (w_beat) begin
                        n_req = i_data;
                        n_val = i_data.number_value;
                        n_cnt = '0;
                    end
                end
                ACT_CHAR: begin
                    if (r_req.char_code == CH_NL) begin
                        n_col = '0;
                        n_row = (w_row_inc >= (ROW_W + 1)'(SCREEN_ROWS)) ? '0 : w_row_inc[ROW_W-1:0];
                    end
                end
                ACT_SETCUR: begin
                    if ({1'b0, r_req.new_col} < 9'(SCREEN_COLS)) begin
                        n_col = COL_W'(r_req.new_col);
                    end
                    if ({1'b0, r_req.new_row} < 9'(SCREEN_ROWS)) begin
                        n_row = ROW_W'(r_req.new_row);
                    end
                end
                ACT_MUL: begin
                    n_prod = 64'(r_val) * 64'(RECIP10);
                end
                ACT_DIGIT: begin
                    w_dig_we = 1'b1;
                    n_val    = w_q;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
                ACT_EMITD: begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
                default: begin
                    n_cnt = r_cnt;
                end
            endcase

            // cell beat and cursor step (also tab, which moves without a beat)
            if (w_emit) begin
                n_out_valid      = 1'b1;
                n_out.cell_index = 11'((r_row * SCREEN_COLS) + r_col);
                n_out.cell_char  = w_emit_char;
                n_out.cell_attr  = r_req.text_color;
                n_out.last_write = w_emit_last;
            end
            if (w_emit || (w_uw.act == ACT_CHAR && r_req.char_code == CH_TAB)) begin
                if (w_col_adv >= COL_W'(SCREEN_COLS)) begin
                    n_col = '0;
                    n_row = (w_row_inc >= (ROW_W + 1)'(SCREEN_ROWS)) ? '0 : w_row_inc[ROW_W-1:0];
                end else begin
                    n_col = w_col_adv;
                end
            end
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_WAIT;
            r_col       <= '0;
            r_row       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_upc       <= n_upc;
            r_col       <= n_col;
            r_row       <= n_row;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_req  <= n_req;
        r_val  <= n_val;
        r_prod <= n_prod;
        r_out  <= n_out;
        if (w_dig_we) begin
            r_dig[r_cnt[DIG_AW-1:0]] <= w_digit;
        end
    end

`ifndef SYNTH
    // cursor always lands on the screen
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < COL_W'(SCREEN_COLS)) && (r_row < ROW_W'(SCREEN_ROWS)))
        else $error("cursor off screen");

    // digit count stays within the scratch
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DIGIT_DEPTH))
        else $error("digit count overflow");

    // printing a digit only with a stored digit pending
    a_emitd_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == U_EMITD) |-> (r_cnt != '0))
        else $error("digit read with empty scratch");

    // a valid request keeps the sequencer busy in the next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_beat && (i_data.req_type == REQ_CHAR || i_data.req_type == REQ_DEC ||
                    i_data.req_type == REQ_HEX || i_data.req_type == REQ_HEX0X ||
                    i_data.req_type == REQ_SETCUR)) |=> !o_ready)
        else $error("request dropped by sequencer");
`endif

endmodule

`default_nettype wire
